// ----- rtl/core/ptic_pkg.sv -----
// Package for the pulse train interval capture block.
// Holds the item codes, register indexes and the result word type.
// Depends on nothing.
package ptic_pkg;

	typedef enum logic [1:0] {
		FUNC_ARM  = 2'd0,
		FUNC_WRAP = 2'd1,
		FUNC_EDGE = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		KIND_SAMPLE = 1'b0,
		KIND_DONE   = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REG_TRIGGER = 2'd0,
		REG_WINDOW  = 2'd1,
		REG_LIMIT   = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] idx;
		logic [31:0] interval;
		logic        last;
	} res_t;

endpackage

// ----- rtl/core/pulse_train_interval_capture.sv -----
// Top level of the pulse train interval capture block: one input-capture
// channel that turns edge and wrap words into interval samples and a done word.
// Depends on ptic_pkg.
//
//   channel  handshake            payload
//   ------   -------------------  ------------------------------------
//   in       in_valid / in_ready  func, stamp, pin_level
//   out      out_valid/out_ready  kind, sample_index, interval_us, last
//   cfg      APB psel/penable     paddr, pwdata -> prdata, pready = 1
//
// An accepted word lands in the input register and is decoded against the session
// state in the next cycle. Its zero, one or two result words enter a two-entry
// output queue when the word retires, and the queue head drives the result port.
// One word a cycle is taken as long as results drain. A two-result word waits only
// until the queue is empty after this cycle's pop, which a draining output always
// allows. A stalled output fills the queue, then the input register, then
// drops in_ready. Reset clears the session as if just armed and loads the
// register defaults; no clearing pass is needed.
module pulse_train_interval_capture #(
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] stamp,
	input  logic        pin_level,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [15:0] sample_index,
	output logic [31:0] interval_us,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// counter masks and wrap weight, all folded at elaboration
	localparam logic [63:0] WrapTicks64 = 64'd1 << COUNTER_BITS;
	localparam logic [31:0] WrapTicks   = WrapTicks64[31:0];
	localparam logic [63:0] CntMask64   = WrapTicks64 - 64'd1;
	localparam logic [31:0] CntMask     = CntMask64[31:0];
	localparam logic [15:0] StampMask   = CntMask64[15:0];

	// configuration registers
	logic        trigger_q;
	logic [31:0] window_q;
	logic [15:0] limit_q;

	// session state
	logic        running_q, finished_q;
	logic [15:0] prev_q, start_q, wraps_q, count_q;
	logic [31:0] wtot_q;

	logic        running_d, finished_d;
	logic [15:0] prev_d, start_d, wraps_d, count_d;
	logic [31:0] wtot_d;

	// input register
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [15:0] stamp_s1;
	logic        pin_s1;

	// output queue, head at entry 0
	ptic_pkg::res_t queue_q [2];
	ptic_pkg::res_t queue_d [2];
	logic [1:0]     cnt_q, cnt_d;

	// results of the word in the input register
	ptic_pkg::res_t res0, res1;
	logic [1:0]     nres;
	logic           pop, fire;
	logic [2:0]     need;

	logic [15:0] stamp_m;
	logic [31:0] interval, elapsed, wtot_inc, ovf_elapsed;
	logic        limited, below, emit, expire;

	logic cfg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= 1'b0;
			window_q  <= 32'hFFFF_FFFF;
			limit_q   <= 16'd0;
		end else if (cfg_wr) begin
			unique case (ptic_pkg::reg_idx_t'(paddr[3:2]))
				ptic_pkg::REG_TRIGGER: trigger_q <= pwdata[0];
				ptic_pkg::REG_WINDOW:  window_q  <= pwdata;
				ptic_pkg::REG_LIMIT:   limit_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ptic_pkg::reg_idx_t'(paddr[3:2]))
			ptic_pkg::REG_TRIGGER: prdata = {31'd0, trigger_q};
			ptic_pkg::REG_WINDOW:  prdata = window_q;
			ptic_pkg::REG_LIMIT:   prdata = {16'd0, limit_q};
			default:               prdata = 32'd0;
		endcase
	end

	// ---------------- decode of the held word ----------------
	assign stamp_m  = stamp_s1 & StampMask;
	assign limited  = (limit_q != 16'd0);
	assign below    = (count_q < limit_q);
	// interval counts each wrap since the last edge as a full counter period
	assign interval = (wraps_q == 16'd0)
		? ((32'(stamp_m) - 32'(prev_q)) & CntMask)
		: (32'(stamp_m) + (32'(wraps_q) << COUNTER_BITS) - 32'(prev_q));
	assign elapsed     = wtot_q + 32'(stamp_m) - 32'(start_q);
	assign wtot_inc    = wtot_q + WrapTicks;
	assign ovf_elapsed = wtot_inc - 32'(start_q);
	assign emit        = limited & below;
	assign expire      = (limited & ~below) | (elapsed > window_q);

	always_comb begin
		running_d  = running_q;
		finished_d = finished_q;
		prev_d     = prev_q;
		start_d    = start_q;
		wraps_d    = wraps_q;
		wtot_d     = wtot_q;
		count_d    = count_q;
		nres       = 2'd0;
		res0       = '{kind: ptic_pkg::KIND_DONE, idx: count_q, interval: 32'd0, last: 1'b1};
		res1       = '{kind: ptic_pkg::KIND_DONE, idx: count_q, interval: 32'd0, last: 1'b1};

		unique case (ptic_pkg::func_t'(func_s1))
			ptic_pkg::FUNC_ARM: begin
				running_d  = 1'b0;
				finished_d = 1'b0;
				prev_d     = 16'd0;
				start_d    = 16'd0;
				wraps_d    = 16'd0;
				wtot_d     = 32'd0;
				count_d    = 16'd0;
			end
			ptic_pkg::FUNC_WRAP: begin
				if (!finished_q && running_q) begin
					wraps_d = wraps_q + 16'd1;
					wtot_d  = wtot_inc;
					if (ovf_elapsed > window_q) begin
						nres       = 2'd1;
						finished_d = 1'b1;
						running_d  = 1'b0;
					end
				end
			end
			ptic_pkg::FUNC_EDGE: begin
				if (!finished_q) begin
					if (running_q) begin
						if (emit) begin
							res0 = '{kind: ptic_pkg::KIND_SAMPLE, idx: count_q,
								interval: interval, last: ~expire};
						end
						nres = {1'b0, emit} + {1'b0, expire};
						if (expire) begin
							// done word reports the count without this sample
							finished_d = 1'b1;
							running_d  = 1'b0;
						end else begin
							if (count_q < ptic_pkg::COUNT_MAX) count_d = count_q + 16'd1;
							prev_d  = stamp_m;
							wraps_d = 16'd0;
						end
					end else begin
						if (pin_s1 == trigger_q) begin
							prev_d    = stamp_m;
							start_d   = stamp_m;
							running_d = 1'b1;
							wtot_d    = 32'd0;
						end
						wraps_d = 16'd0;
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- flow control ----------------
	assign pop  = out_valid & out_ready;
	// queue occupancy after this cycle's pop plus the new results must fit
	assign need = {1'b0, cnt_q} - {2'b00, pop} + {1'b0, nres};
	assign fire = valid_s1 & (need <= 3'd2);
	assign in_ready = ~valid_s1 | fire;

	always_comb begin
		queue_d = queue_q;
		cnt_d   = cnt_q;
		if (pop) begin
			queue_d[0] = queue_q[1];
			cnt_d      = cnt_q - 2'd1;
		end
		if (fire) begin
			if (nres == 2'd2) begin
				queue_d[0] = res0;
				queue_d[1] = res1;
			end else if (nres == 2'd1) begin
				queue_d[cnt_d[0]] = res0;
			end
			cnt_d = cnt_d + nres;
		end
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			cnt_q      <= 2'd0;
			running_q  <= 1'b0;
			finished_q <= 1'b0;
			prev_q     <= 16'd0;
			start_q    <= 16'd0;
			wraps_q    <= 16'd0;
			wtot_q     <= 32'd0;
			count_q    <= 16'd0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			cnt_q <= cnt_d;
			// advance the session only when the held word retires
			if (fire) begin
				running_q  <= running_d;
				finished_q <= finished_d;
				prev_q     <= prev_d;
				start_q    <= start_d;
				wraps_q    <= wraps_d;
				wtot_q     <= wtot_d;
				count_q    <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1  <= func;
			stamp_s1 <= stamp;
			pin_s1   <= pin_level;
		end
		queue_q <= queue_d;
	end

	// ---------------- result port ----------------
	assign out_valid    = (cnt_q != 2'd0);
	assign kind         = queue_q[0].kind;
	assign sample_index = queue_q[0].idx;
	assign interval_us  = queue_q[0].interval;
	assign last         = queue_q[0].last;

endmodule
